// ===== design/dcm_pkg.sv =====
// ----------------------------------------------------------------------------
// dcm_pkg
// Types and constants shared by the signed 64-bit decimal check core:
// beat layouts, scan state, and the decimal digits of the 64-bit limit.
// ----------------------------------------------------------------------------
package dcm_pkg;

    // one character beat of the argument string
    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       last;
    } dcm_in_t;

    // one verdict beat, given for each last beat of a string
    typedef struct packed {
        logic       valid_res;
        logic [7:0] result_code;
    } dcm_out_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_SIGN  = 2'd1,
        PH_BODY  = 2'd2
    } dcm_phase_t;

    typedef enum logic [1:0] {
        CMP_EQUAL   = 2'd0,
        CMP_LESS    = 2'd1,
        CMP_GREATER = 2'd2
    } dcm_cmp_t;

    typedef struct packed {
        dcm_phase_t phase;
        logic       negative;
        logic [7:0] residue;
        logic [4:0] sig_count;
        dcm_cmp_t   limit_cmp;
        logic       bad_char;
    } dcm_state_t;

    localparam dcm_state_t STATE_RESET = '{
        phase:     PH_START,
        negative:  1'b0,
        residue:   8'd0,
        sig_count: 5'd0,
        limit_cmp: CMP_EQUAL,
        bad_char:  1'b0
    };

    localparam logic [4:0] LIMIT_LEN    = 5'd19;
    localparam logic [4:0] COUNT_SAT    = 5'd20;
    localparam logic [7:0] INVALID_CODE = 8'd2;
    localparam logic [3:0] NEG_LAST_DIGIT = 4'd8;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // digits of 9223372036854775807, most significant first
    localparam logic [3:0] LIM_DIGITS [19] = '{
        4'd9, 4'd2, 4'd2, 4'd3, 4'd3, 4'd7, 4'd2, 4'd0, 4'd3, 4'd6,
        4'd8, 4'd5, 4'd4, 4'd7, 4'd7, 4'd5, 4'd8, 4'd0, 4'd7
    };

endpackage

// ===== design/dcm_char_step.sv =====
// ----------------------------------------------------------------------------
// dcm_char_step
// Next scan state for one character: sign, leading zeros, digit count,
// running compare against the 64-bit limit, and residue modulo 256.
// ----------------------------------------------------------------------------
module dcm_char_step (
    input  dcm_pkg::dcm_state_t state,
    input  logic [7:0]          char_code,
    input  logic                has_char,
    output dcm_pkg::dcm_state_t state_next
);

    logic       is_sign;
    logic       is_digit;
    logic [3:0] digit;
    logic [3:0] lim;
    logic [7:0] residue_x10;

    assign is_sign  = (state.phase == dcm_pkg::PH_START)
                   && ((char_code == dcm_pkg::CH_PLUS) || (char_code == dcm_pkg::CH_MINUS));
    assign is_digit = (char_code >= dcm_pkg::CH_ZERO) && (char_code <= dcm_pkg::CH_NINE);
    assign digit    = char_code[3:0];

    // times ten as 8x + 2x, kept to 8 bits
    assign residue_x10 = {state.residue[4:0], 3'b000} + {state.residue[6:0], 1'b0};

    always_comb
    begin
        lim = 4'd0;
        if (state.sig_count < dcm_pkg::LIMIT_LEN)
        begin
            lim = dcm_pkg::LIM_DIGITS[state.sig_count];
        end
        if ((state.sig_count == dcm_pkg::LIMIT_LEN - 5'd1) && state.negative)
        begin
            lim = dcm_pkg::NEG_LAST_DIGIT;
        end
    end

    always_comb
    begin
        state_next = state;
        if (has_char)
        begin
            if (is_sign)
            begin
                state_next.negative = (char_code == dcm_pkg::CH_MINUS);
                state_next.phase    = dcm_pkg::PH_SIGN;
            end
            else if (!is_digit)
            begin
                state_next.phase    = dcm_pkg::PH_BODY;
                state_next.bad_char = 1'b1;
                if ((state.sig_count != 5'd0) && (state.sig_count < dcm_pkg::COUNT_SAT))
                begin
                    state_next.sig_count = state.sig_count + 5'd1;
                end
            end
            else
            begin
                state_next.phase   = dcm_pkg::PH_BODY;
                state_next.residue = residue_x10 + {4'd0, digit};
                // leading zeros only touch the residue and the phase
                if (!((state.sig_count == 5'd0) && (digit == 4'd0)))
                begin
                    if ((state.sig_count < dcm_pkg::LIMIT_LEN)
                        && (state.limit_cmp == dcm_pkg::CMP_EQUAL))
                    begin
                        if (digit < lim)
                        begin
                            state_next.limit_cmp = dcm_pkg::CMP_LESS;
                        end
                        else if (digit > lim)
                        begin
                            state_next.limit_cmp = dcm_pkg::CMP_GREATER;
                        end
                    end
                    if (state.sig_count < dcm_pkg::COUNT_SAT)
                    begin
                        state_next.sig_count = state.sig_count + 5'd1;
                    end
                end
            end
        end
    end

endmodule

// ===== design/dcm_verdict.sv =====
// ----------------------------------------------------------------------------
// dcm_verdict
// Final verdict from the scan state: range and syntax check, and the exit
// code with negative values folded into 0..255.
// ----------------------------------------------------------------------------
module dcm_verdict (
    input  dcm_pkg::dcm_state_t state,
    output dcm_pkg::dcm_out_t   verdict
);

    logic       ok;
    logic [7:0] code;

    always_comb
    begin
        ok = (state.phase == dcm_pkg::PH_BODY) && !state.bad_char;
        if (state.sig_count > dcm_pkg::LIMIT_LEN)
        begin
            ok = 1'b0;
        end
        if ((state.sig_count == dcm_pkg::LIMIT_LEN)
            && (state.limit_cmp == dcm_pkg::CMP_GREATER))
        begin
            ok = 1'b0;
        end
        code = state.negative ? (8'd0 - state.residue) : state.residue;
        verdict.valid_res   = ok;
        verdict.result_code = ok ? code : dcm_pkg::INVALID_CODE;
    end

endmodule

// ===== design/decimal_int64_check_mod256_core.sv =====
// ----------------------------------------------------------------------------
// decimal_int64_check_mod256_core
// Checks a decimal argument string, one character per beat, for a valid
// signed 64-bit integer and gives the value modulo 256 as an exit code.
// ----------------------------------------------------------------------------
// The block takes one character beat per clock cycle while no last beat is
// held back: a beat is registered in an input register, the character logic
// updates the scan state and, on a beat marked last, the verdict is registered
// in an output register. Beats that are not last never wait for the output
// side; a last beat waits only while the previous verdict is still held and
// not taken. An optional leading sign, leading zeros, up to 19 significant
// digits and the 64-bit limit are checked; an invalid string (empty, sign
// only, non-digit, out of range) gives valid_res 0 and result_code 2. After
// each last beat the scan state returns to its reset values for the next
// string.
module decimal_int64_check_mod256_core (
    input  logic              clk,
    input  logic              rst_n,
    // character beats
    input  logic              item_valid,
    output logic              item_ready,
    input  dcm_pkg::dcm_in_t  item,
    // verdict beats
    output logic              res_valid,
    input  logic              res_ready,
    output dcm_pkg::dcm_out_t res
);

    // input register stage
    logic                s1_valid_reg;
    logic                s1_valid_next;
    dcm_pkg::dcm_in_t    s1_data_reg;

    // scan state
    dcm_pkg::dcm_state_t state_reg;
    dcm_pkg::dcm_state_t state_next;
    dcm_pkg::dcm_state_t state_step;

    // output register stage
    logic                out_valid_reg;
    logic                out_valid_next;
    dcm_pkg::dcm_out_t   out_data_reg;
    dcm_pkg::dcm_out_t   verdict;

    logic                out_free;
    logic                s1_advance;

    // the output slot is free when empty or being drained this cycle
    assign out_free   = !out_valid_reg || res_ready;
    // only a last beat needs the output slot
    assign s1_advance = s1_valid_reg && (!s1_data_reg.last || out_free);
    assign item_ready = !s1_valid_reg || s1_advance;

    dcm_char_step u_step (
        .state      (state_reg),
        .char_code  (s1_data_reg.char_code),
        .has_char   (s1_data_reg.has_char),
        .state_next (state_step)
    );

    dcm_verdict u_verdict (
        .state   (state_step),
        .verdict (verdict)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_valid && item_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        state_next = state_reg;
        if (s1_advance)
        begin
            // a finished string starts the next one from reset
            state_next = s1_data_reg.last ? dcm_pkg::STATE_RESET : state_step;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance && s1_data_reg.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            state_reg     <= dcm_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_data_reg <= item;
        end
        if (s1_advance && s1_data_reg.last)
        begin
            out_data_reg <= verdict;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

    // a last beat leaving the input stage always yields a verdict beat
    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_data_reg.last) |=> out_valid_reg)
        else $error("last beat did not load the verdict register");

    // scan state is back at reset after each string
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_data_reg.last) |=> (state_reg == dcm_pkg::STATE_RESET))
        else $error("scan state not cleared after last beat");

    // an invalid verdict carries the invalid code
    a_invalid_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.valid_res)
            |-> (out_data_reg.result_code == dcm_pkg::INVALID_CODE))
        else $error("invalid verdict with wrong code");

    // the significant digit count saturates
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.sig_count <= dcm_pkg::COUNT_SAT)
        else $error("significant digit count past saturation");

    // a held verdict never blocks a beat that is not last
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_data_reg.last) |-> item_ready)
        else $error("input stalled behind a beat that needs no output slot");

endmodule

// ===== test/tb_verdict_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_verdict_pkg
// Verdict scoreboard for the decimal int64 check core: scans each accepted
// character beat into its own copy of the scan state and keeps the verdicts
// due, oldest first, for comparison with the verdict beats.
// ----------------------------------------------------------------------------
package tb_verdict_pkg;

    import dcm_pkg::*;

    localparam logic [7:0] K_PLUS  = "+";
    localparam logic [7:0] K_MINUS = "-";
    localparam logic [7:0] K_ZERO  = "0";
    localparam logic [7:0] K_NINE  = "9";

    localparam logic [4:0] MAX_LEN  = 5'd19;
    localparam logic [4:0] SAT_LEN  = 5'd20;
    localparam logic [7:0] BAD_CODE = 8'd2;

    // 9223372036854775807, most significant digit first
    localparam int unsigned MAX_DIGITS [19] = '{
        9, 2, 2, 3, 3, 7, 2, 0, 3, 6, 8, 5, 4, 7, 7, 5, 8, 0, 7
    };

    class verdict_board;
        dcm_phase_t  phase;
        logic        negative;
        logic [7:0]  residue;
        logic [4:0]  sig_count;
        dcm_cmp_t    cmp;
        logic        bad_char;
        dcm_out_t    verdicts_due[$];
        int unsigned errors;

        function new();
            clear_scan();
            errors = 0;
        endfunction

        function void clear_scan();
            phase     = PH_START;
            negative  = 1'b0;
            residue   = 8'd0;
            sig_count = 5'd0;
            cmp       = CMP_EQUAL;
            bad_char  = 1'b0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void scan_char(logic [7:0] c);
            logic [3:0] d;
            logic [3:0] lim;
            if (phase == PH_START && (c == K_PLUS || c == K_MINUS)) begin
                negative = (c == K_MINUS);
                phase    = PH_SIGN;
                return;
            end
            phase = PH_BODY;
            if (c < K_ZERO || c > K_NINE) begin
                bad_char = 1'b1;
                if (sig_count != 5'd0 && sig_count < SAT_LEN)
                    sig_count++;
                return;
            end
            d       = 4'(c - K_ZERO);
            residue = residue * 8'd10 + {4'd0, d};
            // leading zeros
            if (sig_count == 5'd0 && d == 4'd0)
                return;
            if (sig_count < MAX_LEN && cmp == CMP_EQUAL) begin
                lim = 4'(MAX_DIGITS[sig_count]);
                if (sig_count == MAX_LEN - 5'd1 && negative)
                    lim = 4'd8;
                if (d < lim)
                    cmp = CMP_LESS;
                else if (d > lim)
                    cmp = CMP_GREATER;
            end
            if (sig_count < SAT_LEN)
                sig_count++;
        endfunction

        function void take_beat(dcm_in_t b);
            dcm_out_t v;
            logic     ok;
            if (b.has_char)
                scan_char(b.char_code);
            if (!b.last)
                return;
            ok = (phase == PH_BODY) && !bad_char && (sig_count <= MAX_LEN)
                && !(sig_count == MAX_LEN && cmp == CMP_GREATER);
            v.valid_res   = ok;
            v.result_code = !ok ? BAD_CODE : (negative ? 8'd0 - residue : residue);
            verdicts_due.push_back(v);
            clear_scan();
        endfunction

        function void check_verdict(dcm_out_t got);
            dcm_out_t want;
            if (verdicts_due.size() == 0) begin
                flag($sformatf("unexpected verdict: valid %0d code %0d",
                    got.valid_res, got.result_code));
                return;
            end
            want = verdicts_due.pop_front();
            if (got.valid_res !== want.valid_res || got.result_code !== want.result_code)
                flag($sformatf("verdict mismatch: expected valid %0d code %0d, got valid %0d code %0d",
                    want.valid_res, want.result_code, got.valid_res, got.result_code));
        endfunction

        function int unsigned pending();
            return verdicts_due.size();
        endfunction

        function void close();
            if (verdicts_due.size() != 0)
                flag($sformatf("%0d verdicts never arrived", verdicts_due.size()));
        endfunction
    endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for decimal_int64_check_mod256_core: drives argument strings one
// character beat at a time, directed corner strings first and then random
// numbers, near-limit values and garbage, with random idle bursts on both
// channels, and checks every verdict against the scoreboard prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import dcm_pkg::*;
    import tb_verdict_pkg::*;

    localparam int unsigned ITEM_TARGET    = 1600;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    logic     clk;
    logic     rst_n;
    logic     item_valid;
    logic     item_ready;
    dcm_in_t  item;
    logic     res_valid;
    logic     res_ready;
    dcm_out_t res;

    verdict_board board;

    // characters of the string being built
    logic [7:0]  chars[$];
    int unsigned sent;
    int unsigned quiet_cycles;
    logic        moved;
    // input idle chance in percent per beat, output stall chance in percent, and the calm tail of the run
    int unsigned idle_pct;
    int unsigned stall_pct;
    bit          calm;

    decimal_int64_check_mod256_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one character beat; an idle burst may come first, valid then holds
    // until the beat is taken
    task automatic send_beat(input dcm_in_t b);
        if (!calm && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        item       <= b;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        // every accepted beat counts, gap beats included
        sent++;
        @(negedge clk);
    endtask

    // beats without a character carry random junk in char_code
    function automatic dcm_in_t gap_beat(input logic fin);
        dcm_in_t b;
        b.char_code = 8'($urandom_range(0, 255));
        b.has_char  = 1'b0;
        b.last      = fin;
        return b;
    endfunction

    // send the built string; an empty string or end_gap closes it with a
    // last beat that has no character
    task automatic run_string(input bit end_gap);
        dcm_in_t b;
        for (int i = 0; i < chars.size(); i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_beat(gap_beat(1'b0));
            b.char_code = chars[i];
            b.has_char  = 1'b1;
            b.last      = (i == chars.size() - 1) && !end_gap;
            send_beat(b);
        end
        if (end_gap || chars.size() == 0)
            send_beat(gap_beat(1'b1));
    endtask

    task automatic load_text(input string s);
        chars.delete();
        for (int i = 0; i < s.len(); i++)
            chars.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_digit(input int unsigned lo);
        return K_ZERO + 8'($urandom_range(lo, 9));
    endfunction

    task automatic put_sign();
        case ($urandom_range(0, 2))
            0: chars.push_back(K_PLUS);
            1: chars.push_back(K_MINUS);
            default: ;
        endcase
    endtask

    task automatic put_zeros(input int unsigned most);
        repeat ($urandom_range(0, most))
            chars.push_back(K_ZERO);
    endtask

    // well-formed number, mostly short
    task automatic make_number();
        int unsigned len;
        chars.delete();
        put_sign();
        put_zeros($urandom_range(0, 3) == 0 ? 6 : 1);
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 19) : $urandom_range(1, 6);
        chars.push_back(rand_digit(1));
        for (int i = 1; i < len; i++)
            chars.push_back(rand_digit(0));
    endtask

    // values around the int64 limit, with the sign-dependent last digit
    task automatic make_near_limit();
        bit          neg;
        int unsigned pos;
        chars.delete();
        put_sign();
        neg = (chars.size() != 0 && chars[0] == K_MINUS);
        put_zeros(2);
        pos = chars.size();
        for (int i = 0; i < 19; i++)
            chars.push_back(K_ZERO + 8'(MAX_DIGITS[i]));
        if (neg)
            chars[pos + 18] = K_ZERO + 8'd8;
        case ($urandom_range(0, 6))
            0: ;
            // one digit anywhere changed at random
            1: chars[pos + $urandom_range(0, 18)] = rand_digit(0);
            // just past the limit
            2: chars[pos + 18] = chars[pos + 18] + 8'd1;
            // 18 digits
            3: void'(chars.pop_back());
            // 20 digits and more, count saturation
            4: chars.push_back(rand_digit(0));
            5: repeat ($urandom_range(2, 6)) chars.push_back(rand_digit(0));
            default:
                for (int i = 0; i < 19; i++)
                    chars[pos + i] = K_NINE;
        endcase
    endtask

    // a number with one character damaged, a sign inserted or a random byte added
    task automatic make_broken();
        int unsigned pos;
        make_number();
        pos = $urandom_range(0, chars.size() - 1);
        case ($urandom_range(0, 2))
            0: chars[pos] = 8'($urandom_range(0, 255));
            1: chars.insert($urandom_range(1, chars.size()),
                            $urandom_range(0, 1) ? K_PLUS : K_MINUS);
            default: chars.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    // random bytes, sign alone, zeros with an optional sign, or nothing at all
    task automatic make_noise();
        chars.delete();
        case ($urandom_range(0, 4))
            0: ;
            1: chars.push_back($urandom_range(0, 1) ? K_PLUS : K_MINUS);
            2:
            begin
                put_sign();
                repeat ($urandom_range(1, 5)) chars.push_back(K_ZERO);
            end
            default:
                repeat ($urandom_range(1, 5)) chars.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    // verdict side: random stall bursts, none in the calm tail
    initial
    begin
        int unsigned hold;
        hold      = 0;
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold != 0)
            begin
                hold--;
                res_ready <= 1'b0;
            end
            else if (!calm && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                hold = $urandom_range(0, 18);
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // monitor: both channels sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (item_valid && item_ready)
            begin
                board.take_beat(item);
                moved = 1'b1;
            end
            if (res_valid && res_ready)
            begin
                board.check_verdict(res);
                moved = 1'b1;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // watchdog on cycles with no beat moving on either channel
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int unsigned strings;
        int unsigned pick;
        item_valid   = 1'b0;
        item         = '0;
        rst_n        = 1'b0;
        sent         = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        calm         = 1'b0;
        strings      = 0;
        board        = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed corners: empty string, sign only, zero with and without
        // sign, a string closed by a beat with no character, nul byte, top
        // byte value, second sign, leading zeros
        load_text("");    run_string(1'b1);
        load_text("+");   run_string(1'b0);
        load_text("-");   run_string(1'b0);
        load_text("0");   run_string(1'b0);
        load_text("-0");  run_string(1'b1);
        load_text("-1");  run_string(1'b0);
        load_text("+9");  run_string(1'b1);
        chars.delete(); chars.push_back(8'h00); run_string(1'b0);
        chars.delete(); chars.push_back(8'hFF); run_string(1'b0);
        load_text("1-");  run_string(1'b0);
        load_text("++");  run_string(1'b0);
        load_text("-+1"); run_string(1'b0);
        load_text("007"); run_string(1'b0);

        while (sent < ITEM_TARGET)
        begin
            // new idle profile now and then, including stretches without idling
            if (strings % 30 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 40;
                endcase
            end
            if (sent >= ITEM_TARGET * 85 / 100)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                make_number();
            else if (pick < 70)
                make_near_limit();
            else if (pick < 88)
                make_broken();
            else
                make_noise();
            run_string($urandom_range(0, 7) == 0);
            strings++;
        end
        item_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        board.close();
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== decimal_int64_check_mod256_core.f =====
design/dcm_pkg.sv
design/dcm_char_step.sv
design/dcm_verdict.sv
design/decimal_int64_check_mod256_core.sv
test/tb_verdict_pkg.sv
test/tb_top.sv
